@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes, widths and the queue entry type of the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int RES_W           = 33;
    localparam int OPERAND_W_DFLT  = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int DIV_STEPS       = RES_W;

    localparam logic [3:0] KIND_ADD = 4'd0;
    localparam logic [3:0] KIND_SUB = 4'd1;
    localparam logic [3:0] KIND_MUL = 4'd2;
    localparam logic [3:0] KIND_DIV = 4'd3;
    localparam logic [3:0] KIND_NEG = 4'd4;
    localparam logic [3:0] KIND_LT  = 4'd5;
    localparam logic [3:0] KIND_LE  = 4'd6;
    localparam logic [3:0] KIND_EQ  = 4'd7;
    localparam logic [3:0] KIND_GT  = 4'd8;
    localparam logic [3:0] KIND_GE  = 4'd9;

    // One classified word: unreduced fraction plus flags.
    typedef struct packed {
        logic signed [RES_W-1:0] num;
        logic signed [RES_W-1:0] den;
        logic                    cmp;
        logic                    err;
        logic                    reduce;
    } rau_item_t;

    // Handshake between queue and either neighbour.
    typedef struct packed {
        logic push;
        logic pop;
    } rau_qctl_t;

endpackage

@@ rtl/rau_div.sv @@
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div
    import rau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [RES_W-1:0] dividend,
    input  logic [RES_W-1:0] divisor,
    output logic             done,
    output logic [RES_W-1:0] quot,
    output logic [RES_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0] q_reg, q_next;
    logic [RES_W-1:0] r_reg, r_next;
    logic [RES_W-1:0] dvs_reg, dvs_next;
    logic [RES_W:0]   shifted;
    logic [RES_W:0]   diff;

    assign shifted = {r_reg, q_reg[RES_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS);
            q_next    = dividend;
            r_next    = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[RES_W]) begin
                r_next = diff[RES_W-1:0];
                q_next = {q_reg[RES_W-2:0], 1'b1};
            end else begin
                r_next = shifted[RES_W-1:0];
                q_next = {q_reg[RES_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

@@ rtl/rau_front.sv @@
// ----------------------------------------------------------------------------
// rau_front
// Accepts a word, forms the cross products and classifies the operation.
// ----------------------------------------------------------------------------
module rau_front
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_W_DFLT
)
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [3:0]                      s_kind,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_den,
    input  logic                            q_full,
    output logic                            q_push,
    output rau_item_t                       q_item
);

    localparam int PW = 2 * OPERAND_WIDTH;
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [3:0] kind_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [RES_W-1:0] anbd_reg, adbn_reg, adbd_reg, anbn_reg;
    logic signed [PW-1:0]    p_anbd, p_adbn, p_adbd, p_anbn;
    logic signed [PW+RES_W-1:0] e_anbd, e_adbn, e_adbd, e_anbn;
    logic signed [OPERAND_WIDTH+RES_W-1:0] e_an, e_ad;
    logic signed [RES_W-1:0] an33, ad33;
    rau_item_t item;
    logic      frac;

    assign p_anbd = an_reg * bd_reg;
    assign p_adbn = ad_reg * bn_reg;
    assign p_adbd = ad_reg * bd_reg;
    assign p_anbn = an_reg * bn_reg;
    assign e_anbd = (PW+RES_W)'(p_anbd);
    assign e_adbn = (PW+RES_W)'(p_adbn);
    assign e_adbd = (PW+RES_W)'(p_adbd);
    assign e_anbn = (PW+RES_W)'(p_anbn);
    assign e_an   = (OPERAND_WIDTH+RES_W)'(an_reg);
    assign e_ad   = (OPERAND_WIDTH+RES_W)'(ad_reg);
    assign an33   = e_an[RES_W-1:0];
    assign ad33   = e_ad[RES_W-1:0];

    always_comb begin
        item     = '0;
        item.den = RES_W'(1);
        frac     = 1'b1;
        case (kind_reg)
            KIND_ADD: begin
                item.num = anbd_reg + adbn_reg;
                item.den = adbd_reg;
            end
            KIND_SUB: begin
                item.num = anbd_reg - adbn_reg;
                item.den = adbd_reg;
            end
            KIND_MUL: begin
                item.num = anbn_reg;
                item.den = adbd_reg;
            end
            KIND_DIV: begin
                item.num = anbd_reg;
                item.den = adbn_reg;
            end
            KIND_NEG: begin
                item.num = -an33;
                item.den = ad33;
            end
            KIND_LT: begin frac = 1'b0; item.cmp = anbd_reg <  adbn_reg; end
            KIND_LE: begin frac = 1'b0; item.cmp = anbd_reg <= adbn_reg; end
            KIND_EQ: begin frac = 1'b0; item.cmp = anbd_reg == adbn_reg; end
            KIND_GT: begin frac = 1'b0; item.cmp = anbd_reg >  adbn_reg; end
            KIND_GE: begin frac = 1'b0; item.cmp = anbd_reg >= adbn_reg; end
            default: frac = 1'b0;
        endcase
        if (!frac) begin
            item.num = '0;
            item.den = RES_W'(1);
        end else if (item.den == '0) begin
            item.num = '0;
            item.den = RES_W'(1);
            item.err = 1'b1;
        end else begin
            item.reduce = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (s_valid) state_next = F_MUL;
            F_MUL:   state_next = F_PUSH;
            F_PUSH:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == F_IDLE && s_valid) begin
            kind_reg <= s_kind;
            an_reg   <= s_a_num;
            ad_reg   <= s_a_den;
            bn_reg   <= s_b_num;
            bd_reg   <= s_b_den;
        end
        if (state_reg == F_MUL) begin
            anbd_reg <= e_anbd[RES_W-1:0];
            adbn_reg <= e_adbn[RES_W-1:0];
            adbd_reg <= e_adbd[RES_W-1:0];
            anbn_reg <= e_anbn[RES_W-1:0];
        end
    end

    assign s_ready = (state_reg == F_IDLE);
    assign q_push  = (state_reg == F_PUSH) && !q_full;
    assign q_item  = item;

endmodule

@@ rtl/rau_queue.sv @@
// ----------------------------------------------------------------------------
// rau_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module rau_queue
    import rau_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  rau_qctl_t ctl,
    input  rau_item_t wr_item,
    output rau_item_t rd_item,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rau_item_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (ctl.push) wp_reg <= bump(wp_reg);
            if (ctl.pop)  rp_reg <= bump(rp_reg);
            if (ctl.push && !ctl.pop)      cnt_reg <= cnt_reg + CNT_W'(1);
            else if (ctl.pop && !ctl.push) cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (ctl.push) mem[wp_reg] <= wr_item;
    end

    assign rd_item = mem[rp_reg];
    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);

endmodule

@@ rtl/rau_back.sv @@
// ----------------------------------------------------------------------------
// rau_back
// Reduces a fraction by Euclid's rule on a shared divider and holds the result.
// ----------------------------------------------------------------------------
module rau_back
    import rau_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  rau_item_t               q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [RES_W-1:0] m_res_num,
    output logic signed [RES_W-1:0] m_res_den,
    output logic                    m_compare_true,
    output logic                    m_div_zero
);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_EGO   = 4'd1;
    localparam logic [3:0] B_EWAIT = 4'd2;
    localparam logic [3:0] B_NGO   = 4'd3;
    localparam logic [3:0] B_NWAIT = 4'd4;
    localparam logic [3:0] B_DGO   = 4'd5;
    localparam logic [3:0] B_DWAIT = 4'd6;
    localparam logic [3:0] B_OUT   = 4'd7;

    logic [3:0] state_reg;
    logic signed [RES_W-1:0] n_reg, d_reg, on_reg, od_reg, g_reg;
    logic signed [RES_W-1:0] rn_reg, rd_reg;
    logic cmp_reg, err_reg;

    logic             dv_start, dv_done;
    logic [RES_W-1:0] dv_a, dv_b, dv_q, dv_r;
    logic signed [RES_W-1:0] dv_sa, dv_sb, rem_s, quo_s;

    function automatic logic [RES_W-1:0] mag(input logic signed [RES_W-1:0] v);
        return v[RES_W-1] ? RES_W'(-v) : v;
    endfunction

    always_comb begin
        dv_sa = n_reg;
        dv_sb = d_reg;
        case (state_reg)
            B_NGO, B_NWAIT: begin dv_sa = on_reg; dv_sb = g_reg; end
            B_DGO, B_DWAIT: begin dv_sa = od_reg; dv_sb = g_reg; end
            default: ;
        endcase
    end

    assign dv_a     = mag(dv_sa);
    assign dv_b     = mag(dv_sb);
    assign dv_start = (state_reg == B_EGO) || (state_reg == B_NGO) || (state_reg == B_DGO);
    // Truncating division: remainder follows dividend, quotient the sign product.
    assign rem_s    = dv_sa[RES_W-1] ? -$signed(dv_r) : $signed(dv_r);
    assign quo_s    = (dv_sa[RES_W-1] ^ dv_sb[RES_W-1]) ? -$signed(dv_q) : $signed(dv_q);

    rau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_a),
        .divisor  (dv_b),
        .done     (dv_done),
        .quot     (dv_q),
        .rem      (dv_r)
    );

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            case (state_reg)
                B_IDLE: if (!q_empty) begin
                    state_reg <= q_item.reduce ? B_EGO : B_OUT;
                end
                B_EGO:   state_reg <= B_EWAIT;
                B_EWAIT: if (dv_done) begin
                    state_reg <= (rem_s == '0) ? B_NGO : B_EGO;
                end
                B_NGO:   state_reg <= B_NWAIT;
                B_NWAIT: if (dv_done) state_reg <= B_DGO;
                B_DGO:   state_reg <= B_DWAIT;
                B_DWAIT: if (dv_done) state_reg <= B_OUT;
                B_OUT:   if (m_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
        if (q_pop) begin
            n_reg   <= q_item.num;
            d_reg   <= q_item.den;
            on_reg  <= q_item.num;
            od_reg  <= q_item.den;
            rn_reg  <= q_item.num;
            rd_reg  <= q_item.den;
            cmp_reg <= q_item.cmp;
            err_reg <= q_item.err;
        end
        if (state_reg == B_EWAIT && dv_done) begin
            if (rem_s == '0) begin
                g_reg <= d_reg;
            end else begin
                n_reg <= d_reg;
                d_reg <= rem_s;
            end
        end
        if (state_reg == B_NWAIT && dv_done) rn_reg <= quo_s;
        if (state_reg == B_DWAIT && dv_done) rd_reg <= quo_s;
    end

    assign m_valid        = (state_reg == B_OUT);
    assign m_res_num      = rn_reg;
    assign m_res_den      = rd_reg;
    assign m_compare_true = cmp_reg;
    assign m_div_zero     = err_reg;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add, subtract, multiply, divide, negate and compare, with reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word carries s_kind and two fractions a and b.
//   Result channel m_*: one word per input word, in order: reduced numerator
//   and denominator, comparison outcome and a zero-denominator flag.
//   Front: takes a word, registers the four cross products, classifies the
//   operation and pushes into a two-entry queue, one word at a time.
//   Back: reduces by Euclid's rule with truncating remainder on one shared
//   restoring divider, then divides numerator and denominator by g.
//   Comparisons and errors skip the divider; for fractions the divider
//   sets throughput.
//   Reset: aresetn clears both state machines and empties the queue.
//   Stall: a held result blocks the back; the front keeps taking words until
//   the queue is full and it holds one word of its own, then drops s_ready.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_W_DFLT
)
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [3:0]                      s_kind,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_b_den,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [RES_W-1:0]         m_res_num,
    output logic signed [RES_W-1:0]         m_res_den,
    output logic                            m_compare_true,
    output logic                            m_div_zero
);

    rau_item_t push_item, head_item;
    rau_qctl_t qctl;
    logic      q_full, q_empty;

    // Front: accept and classify.
    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_a_num (s_a_num),
        .s_a_den (s_a_den),
        .s_b_num (s_b_num),
        .s_b_den (s_b_den),
        .q_full  (q_full),
        .q_push  (qctl.push),
        .q_item  (push_item)
    );

    // Hold classified words until the back is free.
    rau_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (qctl),
        .wr_item (push_item),
        .rd_item (head_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: reduce and present the result word.
    rau_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_item         (head_item),
        .q_pop          (qctl.pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_res_num      (m_res_num),
        .m_res_den      (m_res_den),
        .m_compare_true (m_compare_true),
        .m_div_zero     (m_div_zero)
    );

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_zero |-> m_res_num == '0 && m_res_den == RES_W'(1))
        else $error("error word not 0/1");

    a_cmp_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_true |-> !m_div_zero)
        else $error("comparison flagged as error");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_res_den != '0)
        else $error("zero denominator delivered");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !qctl.push)
        else $error("queue overrun");

endmodule
